// ----- src/bcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// bcdt_pkg
// Shared types and codes for the block claim and duplicate tracker.
// ----------------------------------------------------------------------------
package bcdt_pkg;

  localparam logic [1:0] FUNC_CLAIM   = 2'd0;
  localparam logic [1:0] FUNC_RESCAN  = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;
  localparam logic [1:0] FUNC_NEWINO  = 2'd3;

  localparam logic [1:0] ACT_KEEP = 2'd0;
  localparam logic [1:0] ACT_SKIP = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_MANY_BAD = 3'd3;
  localparam logic [2:0] ST_MANY_DUP = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_RELEASED = 3'd6;

  localparam logic [1:0] REG_FIRST = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_BAD   = 2'd2;
  localparam logic [1:0] REG_DUP   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] block;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  status;
    logic        mark_clear;
    logic [15:0] used_total;
    logic [7:0]  dup_entries;
    logic [7:0]  dup_distinct;
  } res_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,  // latch request, start bitmap read
    OP_DECIDE = 4'd2,  // evaluate range and bitmap, choose path
    OP_SCAN   = 4'd3,  // compare one table entry, issue next read
    OP_MOVE   = 4'd4,  // one move step (table update or bitmap clear)
    OP_SWEEP  = 4'd5,  // clear one bitmap word
    OP_DONE   = 4'd6   // emit result
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic need_scan;
    logic need_move;
    logic scan_end;
    logic move_last;
  } stat_t;

endpackage

// ----- src/bcdt_ram.sv -----
// ----------------------------------------------------------------------------
// bcdt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/bcdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcdt_ctrl
// Sequencer: clearing sweep after reset, then one request at a time.
// ----------------------------------------------------------------------------
module bcdt_ctrl
  import bcdt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output logic  busy,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_SWEEP  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_WAIT   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_MOVE   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (st.need_scan) state_next = S_SCAN;
        else              state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (st.scan_end) begin
          state_next = st.need_move ? S_MOVE : S_DONE;
        end
      end
      S_MOVE: begin
        cmd.op = OP_MOVE;
        if (st.move_last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.op     = OP_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- src/bcdt_dp.sv -----
// ----------------------------------------------------------------------------
// bcdt_dp
// Datapath: bitmap RAM, duplicate table RAM, counters and result register.
// ----------------------------------------------------------------------------
module bcdt_dp
  import bcdt_pkg::*;
#(
  parameter int BLOCK_SPACE = 65536,
  parameter int DUP_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  req_t        req,
  input  cmd_t        cmd,
  output stat_t       st,
  output logic        done,
  output res_t        result
);

  localparam int WBITS = 16;
  localparam int WDEPTH = (BLOCK_SPACE + WBITS - 1) / WBITS;
  localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int TAW = $clog2(DUP_ENTRIES);
  localparam int CW = TAW + 1;

  logic [15:0] first_blk, blk_limit;
  logic [7:0]  bad_limit, dup_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_blk <= 16'd2;
      blk_limit <= 16'hFFFF;
      bad_limit <= 8'd10;
      dup_limit <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST: first_blk <= cfg_data;
        REG_LIMIT: blk_limit <= cfg_data;
        REG_BAD:   bad_limit <= cfg_data[7:0];
        REG_DUP:   dup_limit <= cfg_data[7:0];
        default:   ;
      endcase
    end
  end

  // Request and state registers.
  logic [1:0]    func;
  logic [15:0]   blk;
  logic [CW-1:0] tend, dend;
  logic [7:0]    bad_run, dup_run;
  logic [15:0]   used;
  logic [WAW-1:0] sweep_addr;

  // Bitmap RAM.
  logic           bm_we;
  logic [WAW-1:0] bm_addr;
  logic [15:0]    bm_wdata, bm_rdata;
  logic [15:0]    word;

  bcdt_ram #(.WIDTH(WBITS), .DEPTH(WDEPTH)) u_bitmap (
    .clk(clk), .we(bm_we), .addr(bm_addr), .wdata(bm_wdata), .rdata(bm_rdata)
  );

  // Table RAM.
  logic           tb_we;
  logic [TAW-1:0] tb_addr;
  logic [15:0]    tb_wdata, tb_rdata;

  bcdt_ram #(.WIDTH(16), .DEPTH(DUP_ENTRIES)) u_table (
    .clk(clk), .we(tb_we), .addr(tb_addr), .wdata(tb_wdata), .rdata(tb_rdata)
  );

  // Scan and move sequencing.
  logic [CW-1:0] idx;        // entry whose data appears at tb_rdata
  logic [CW-1:0] scan_lim;
  logic          found;
  logic [CW-1:0] hit;
  logic [1:0]    mstep;      // move micro-step
  logic [15:0]   tmp;
  logic [1:0]    action;
  logic [2:0]    status;
  logic          mark;
  logic          done_r;

  logic out_rng, bit_busy;
  logic [7:0] bad_inc, dup_inc;
  logic [3:0] bsel;

  assign bsel     = blk[3:0];
  assign out_rng  = (blk < first_blk) || (blk >= blk_limit) ||
                    ({1'b0, blk} >= 17'(BLOCK_SPACE));
  assign bit_busy = bm_rdata[bsel];
  assign bad_inc  = (bad_run == 8'hFF) ? bad_run : bad_run + 8'd1;
  assign dup_inc  = (dup_run == 8'hFF) ? dup_run : dup_run + 8'd1;

  logic rd_valid;  // a read was issued for idx last cycle
  logic match;
  assign match = rd_valid && (idx < scan_lim) && (tb_rdata == blk);

  assign st.sweep_last = (sweep_addr == WAW'(WDEPTH - 1));
  assign st.need_scan  = (func == FUNC_CLAIM) ? (!out_rng && bit_busy &&
                           (dup_inc < dup_limit) &&
                           (tend < CW'(DUP_ENTRIES)) && (dend < CW'(DUP_ENTRIES)))
                         : (func == FUNC_RESCAN) ? !out_rng
                         : (func == FUNC_RELEASE) ? (!out_rng && bit_busy) : 1'b0;
  assign st.scan_end   = match || (idx >= scan_lim);
  assign st.need_move  = match || ((func == FUNC_CLAIM)) ||
                         (func == FUNC_RELEASE);
  assign st.move_last  = (mstep == 2'd3);

  // Move program per function (steps 0..3):
  //  claim hit  : write tbl[tend]=blk.
  //  claim miss : read tbl[dend]; wait; write tbl[tend]=data; write tbl[dend]=blk.
  //  rescan hit : read tbl[dend-1]; wait; write tbl[hit]=data; write tbl[dend-1]=blk.
  //  release hit: read tbl[tend-1]; wait; write tbl[hit]=data.
  //  release miss: clear bit (step 0 writes bitmap).
  always_comb begin
    bm_we    = 1'b0;
    bm_addr  = blk[WAW+3:4];
    bm_wdata = word;
    tb_we    = 1'b0;
    tb_addr  = idx[TAW-1:0];
    tb_wdata = blk;
    case (cmd.op)
      OP_SWEEP: begin
        bm_we    = 1'b1;
        bm_addr  = sweep_addr;
        bm_wdata = '0;
      end
      OP_LOAD: begin
        bm_addr = req.block[WAW+3:4];
      end
      OP_DECIDE: begin
        tb_addr = '0;
        if (func == FUNC_CLAIM && !out_rng && !bit_busy) begin
          bm_we    = 1'b1;
          bm_wdata = bm_rdata | (16'd1 << bsel);
        end
      end
      OP_SCAN: begin
        tb_addr = TAW'(idx + CW'(1));
        if (match || idx >= scan_lim) begin
          case (func)
            FUNC_CLAIM:   tb_addr = dend[TAW-1:0];
            FUNC_RESCAN:  tb_addr = TAW'(dend - CW'(1));
            default:      tb_addr = TAW'(tend - CW'(1));
          endcase
        end
      end
      OP_MOVE: begin
        case (func)
          FUNC_CLAIM: begin
            if (found) begin
              tb_we   = (mstep == 2'd0);
              tb_addr = tend[TAW-1:0];
            end else begin
              tb_we    = (mstep == 2'd2) || (mstep == 2'd3);
              tb_addr  = (mstep == 2'd2) ? tend[TAW-1:0] : dend[TAW-1:0];
              tb_wdata = (mstep == 2'd2) ? tmp : blk;
            end
          end
          FUNC_RESCAN: begin
            tb_we    = (mstep == 2'd2) || (mstep == 2'd3);
            tb_addr  = (mstep == 2'd2) ? hit[TAW-1:0] : TAW'(dend - CW'(1));
            tb_wdata = (mstep == 2'd2) ? tmp : blk;
          end
          default: begin
            if (found) begin
              tb_we    = (mstep == 2'd2);
              tb_addr  = (mstep == 2'd2) ? hit[TAW-1:0] : TAW'(tend - CW'(1));
              tb_wdata = tmp;
            end else begin
              bm_we    = (mstep == 2'd0);
              bm_wdata = word & ~(16'd1 << bsel);
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tend       <= '0;
      dend       <= '0;
      bad_run    <= '0;
      dup_run    <= '0;
      used       <= '0;
      sweep_addr <= '0;
      done_r     <= 1'b0;
      rd_valid   <= 1'b0;
      mstep      <= '0;
    end else begin
      done_r <= 1'b0;
      case (cmd.op)
        OP_SWEEP: sweep_addr <= sweep_addr + WAW'(1);
        OP_LOAD: begin
          func <= req.func;
          blk  <= req.block;
        end
        OP_DECIDE: begin
          word     <= bm_rdata;
          found    <= 1'b0;
          idx      <= '0;
          rd_valid <= 1'b1;
          mstep    <= '0;
          mark     <= 1'b0;
          action   <= ACT_KEEP;
          status   <= ST_OK;
          scan_lim <= (func == FUNC_RELEASE) ? tend : dend;
          case (func)
            FUNC_CLAIM: begin
              if (out_rng) begin
                mark    <= 1'b1;
                bad_run <= bad_inc;
                action  <= (bad_inc >= bad_limit) ? ACT_STOP : ACT_SKIP;
                status  <= (bad_inc >= bad_limit) ? ST_MANY_BAD : ST_BAD;
              end else if (bit_busy) begin
                mark    <= 1'b1;
                dup_run <= dup_inc;
                if (dup_inc >= dup_limit) begin
                  action <= ACT_STOP;
                  status <= ST_MANY_DUP;
                end else if (tend >= CW'(DUP_ENTRIES) || dend >= CW'(DUP_ENTRIES)) begin
                  action <= ACT_STOP;
                  status <= ST_FULL;
                end else begin
                  status <= ST_DUP;
                end
              end else begin
                used <= used + 16'd1;
              end
            end
            FUNC_NEWINO: begin
              bad_run <= '0;
              dup_run <= '0;
            end
            default: begin
              if (out_rng) begin
                action <= ACT_SKIP;
                status <= ST_BAD;
              end
            end
          endcase
        end
        OP_SCAN: begin
          idx <= idx + CW'(1);
          if (match) begin
            found <= 1'b1;
            hit   <= idx;
          end
        end
        OP_MOVE: begin
          mstep <= mstep + 2'd1;
          if (mstep == 2'd2) tmp <= tb_rdata;
          if (mstep == 2'd1) tmp <= tb_rdata;
          if (mstep == 2'd3) begin
            case (func)
              FUNC_CLAIM: begin
                tend <= tend + CW'(1);
                if (!found) dend <= dend + CW'(1);
              end
              FUNC_RESCAN: begin
                mark   <= 1'b1;
                status <= ST_DUP;
                dend   <= dend - CW'(1);
                if (dend == CW'(1)) action <= ACT_STOP;
              end
              default: begin
                if (found) begin
                  tend   <= tend - CW'(1);
                  status <= ST_RELEASED;
                end else begin
                  used <= used - 16'd1;
                end
              end
            endcase
          end
        end
        OP_DONE: done_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // tmp holds data read at step 1 (address issued at scan end or step 0).
  assign done = done_r;
  always_comb begin
    result.action       = action;
    result.status       = status;
    result.mark_clear   = mark;
    result.used_total   = used;
    result.dup_entries  = 8'(tend);
    result.dup_distinct = 8'(dend);
  end

  // Counters never pass the table depth.
  a_tend: assert property (@(posedge clk) disable iff (rst)
    tend <= CW'(DUP_ENTRIES)) else $error("table end beyond depth");
  a_dend: assert property (@(posedge clk) disable iff (rst)
    dend <= CW'(DUP_ENTRIES)) else $error("distinct end beyond depth");
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

endmodule

// ----- src/block_claim_dup_tracker_top.sv -----
// ----------------------------------------------------------------------------
// block_claim_dup_tracker_top
// Block bookkeeping for a filesystem check: busy bitmap and duplicate table.
// ----------------------------------------------------------------------------
//   Channel   Handshake          Payload
//   request   start / busy       req (func, block)
//   result    done strobe        res (action, status, counts)
//   config    cfg_we             cfg_index, cfg_data
//
// After reset the bitmap RAM is cleared one 16-bit word per cycle; busy stays
// high meanwhile. A request that needs no table search passes through the
// wait, decide and done states before its result is shown. A search compares
// one table entry per cycle, limited by the single table RAM port, and a table
// update then runs through the move steps. busy is low again in the result
// cycle. The result is shown on res for one cycle with done high; the receiver
// cannot stall it.
module block_claim_dup_tracker_top
  import bcdt_pkg::*;
#(
  parameter int BLOCK_SPACE = 65536,
  parameter int DUP_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  // The controller sequences the sweep, decision, scan and move phases.
  bcdt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .busy(busy), .cmd(cmd)
  );

  // The datapath owns all storage and the result register.
  bcdt_dp #(.BLOCK_SPACE(BLOCK_SPACE), .DUP_ENTRIES(DUP_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .cmd(cmd), .st(st), .done(done),
    .result(res)
  );

endmodule
